// ===== design/float_literal_syntax_checker_top_assert.svh =====
// ----------------------------------------------------------------------------
// float literal syntax checker assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FLOAT_LITERAL_SYNTAX_CHECKER_TOP_ASSERT_SVH
`define FLOAT_LITERAL_SYNTAX_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define FLSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("flsc assertion failed");

// next-cycle implication
`define FLSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("flsc assertion failed");

`endif

// ===== design/flsc_pkg.sv =====
// ----------------------------------------------------------------------------
// flsc_pkg
// types, character codes and canonical patterns for the float literal checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flsc_pkg;

   typedef enum logic [3:0] {
      PH_START,
      PH_SIGN,
      PH_INT,
      PH_DOT,
      PH_EXP,
      PH_EXP_SIGN,
      PH_EXP_DIG,
      PH_WORD,
      PH_DEAD
   } phase_type;

   typedef enum logic [2:0] {
      W_NONE,
      W_N,
      W_NA,
      W_NAN,
      W_I,
      W_IN,
      W_INF
   } word_type;

   typedef enum logic [2:0] {
      CLS_INVALID,
      CLS_FINITE,
      CLS_NAN_POS,
      CLS_NAN_NEG,
      CLS_INF_POS,
      CLS_INF_NEG
   } class_type;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } beat_type;

   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_I  = 8'h69;
   localparam logic [7:0] CH_LO_N  = 8'h6e;

   localparam logic [63:0] PAT32_INVALID = 64'h0000_0000_7fc0_0001;
   localparam logic [63:0] PAT32_NAN_POS = 64'h0000_0000_7fc0_0000;
   localparam logic [63:0] PAT32_NAN_NEG = 64'h0000_0000_ffc0_0000;
   localparam logic [63:0] PAT32_INF_POS = 64'h0000_0000_7f80_0000;
   localparam logic [63:0] PAT32_INF_NEG = 64'h0000_0000_ff80_0000;
   localparam logic [63:0] PAT64_INVALID = 64'h7ff8_0000_0000_0001;
   localparam logic [63:0] PAT64_NAN_POS = 64'h7ff8_0000_0000_0000;
   localparam logic [63:0] PAT64_NAN_NEG = 64'hfff8_0000_0000_0000;
   localparam logic [63:0] PAT64_INF_POS = 64'h7ff0_0000_0000_0000;
   localparam logic [63:0] PAT64_INF_NEG = 64'hfff0_0000_0000_0000;
   localparam logic [63:0] PAT_FINITE    = 64'h0;

   function automatic logic [63:0] canon_pattern(class_type cls, logic dbl);
      logic [63:0] pat;
      case (cls)
         CLS_INVALID: pat = dbl ? PAT64_INVALID : PAT32_INVALID;
         CLS_FINITE:  pat = PAT_FINITE;
         CLS_NAN_POS: pat = dbl ? PAT64_NAN_POS : PAT32_NAN_POS;
         CLS_NAN_NEG: pat = dbl ? PAT64_NAN_NEG : PAT32_NAN_NEG;
         CLS_INF_POS: pat = dbl ? PAT64_INF_POS : PAT32_INF_POS;
         CLS_INF_NEG: pat = dbl ? PAT64_INF_NEG : PAT32_INF_NEG;
         default:     pat = dbl ? PAT64_INVALID : PAT32_INVALID;
      endcase
      return pat;
   endfunction

endpackage

// ===== design/flsc_grammar.sv =====
// ----------------------------------------------------------------------------
// flsc_grammar
// grammar state machine, one character per step, class of the closing beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flsc_grammar
   import flsc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      step_en,
   input  beat_type  beat,
   output class_type cls
);

   phase_type phase_ff, phase_in;
   word_type  word_ff, word_in;
   logic      neg_ff, neg_in;
   logic      seen_ff, seen_in;

   logic is_sign;
   logic is_digit;
   logic is_exp;

   assign is_sign  = (beat.text == CH_PLUS) || (beat.text == CH_MINUS);
   assign is_digit = (beat.text >= CH_ZERO) && (beat.text <= CH_NINE);
   assign is_exp   = (beat.text == CH_LO_E) || (beat.text == CH_UP_E);

   // next state
   always_comb begin
      phase_in = PH_DEAD;
      word_in  = word_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      case (phase_ff)
         PH_START, PH_SIGN: begin
            if ((phase_ff == PH_START) && is_sign) begin
               phase_in = PH_SIGN;
               neg_in   = (beat.text == CH_MINUS);
            end else if (beat.text == CH_LO_N) begin
               phase_in = PH_WORD;
               word_in  = W_N;
            end else if (beat.text == CH_LO_I) begin
               phase_in = PH_WORD;
               word_in  = W_I;
            end else if (is_digit) begin
               phase_in = PH_INT;
               seen_in  = 1'b1;
            end else if (beat.text == CH_POINT) begin
               phase_in = PH_DOT;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               phase_in = PH_INT;
            end else if (beat.text == CH_POINT) begin
               phase_in = PH_DOT;
            end else if (is_exp) begin
               phase_in = PH_EXP;
            end
         end
         PH_DOT: begin
            if (is_digit) begin
               phase_in = PH_DOT;
               seen_in  = 1'b1;
            end else if (is_exp && seen_ff) begin
               phase_in = PH_EXP;
            end
         end
         PH_EXP, PH_EXP_SIGN, PH_EXP_DIG: begin
            if ((phase_ff == PH_EXP) && is_sign) begin
               phase_in = PH_EXP_SIGN;
            end else if (is_digit) begin
               phase_in = PH_EXP_DIG;
            end
         end
         PH_WORD: begin
            if ((word_ff == W_N) && (beat.text == CH_LO_A)) begin
               phase_in = PH_WORD;
               word_in  = W_NA;
            end else if ((word_ff == W_NA) && (beat.text == CH_LO_N)) begin
               phase_in = PH_WORD;
               word_in  = W_NAN;
            end else if ((word_ff == W_I) && (beat.text == CH_LO_N)) begin
               phase_in = PH_WORD;
               word_in  = W_IN;
            end else if ((word_ff == W_IN) && (beat.text == CH_LO_F)) begin
               phase_in = PH_WORD;
               word_in  = W_INF;
            end
         end
         default: begin
            phase_in = PH_DEAD;
         end
      endcase
   end

   // class seen as if this beat closed the literal
   always_comb begin
      cls = CLS_INVALID;
      case (phase_in)
         PH_INT, PH_EXP_DIG: begin
            cls = CLS_FINITE;
         end
         PH_DOT: begin
            cls = seen_in ? CLS_FINITE : CLS_INVALID;
         end
         PH_WORD: begin
            if (word_in == W_NAN) begin
               cls = neg_in ? CLS_NAN_NEG : CLS_NAN_POS;
            end else if (word_in == W_INF) begin
               cls = neg_in ? CLS_INF_NEG : CLS_INF_POS;
            end
         end
         default: begin
            cls = CLS_INVALID;
         end
      endcase
   end

   // state clears after the closing beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         word_ff  <= W_NONE;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (step_en) begin
         if (beat.last) begin
            phase_ff <= PH_START;
            word_ff  <= W_NONE;
            neg_ff   <= 1'b0;
            seen_ff  <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            word_ff  <= word_in;
            neg_ff   <= neg_in;
            seen_ff  <= seen_in;
         end
      end
   end

endmodule

// ===== design/float_literal_syntax_checker_top.sv =====
// ----------------------------------------------------------------------------
// float_literal_syntax_checker_top
// throughput: one character per cycle unless a closing beat waits behind an
//   untaken result; one grammar step between the input register and the
//   result register
// reset: synchronous, active high; grammar returns to start, no beat pending,
//   double width mode set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_literal_syntax_checker_top
   import flsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // character beats
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_is_last,

   // one result per literal
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_literal_class,
   output logic [63:0] rsp_canonical_pattern,

   // mode register
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // input register
   logic     in_valid_ff, in_valid_in;
   beat_type in_beat_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   class_type   out_class_ff;
   logic [63:0] out_pattern_ff;

   // 1 selects f64 patterns
   logic mode_ff;

   logic      advance;
   logic      load_out;
   class_type step_class;

   // a held beat moves on unless it closes a literal while the result
   // register still holds an untaken result
   assign advance   = in_valid_ff && (!in_beat_ff.last || !out_valid_ff || rsp_ready);
   assign load_out  = advance && in_beat_ff.last;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ready);

   flsc_grammar u_grammar (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .beat    (in_beat_ff),
      .cls     (step_class)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // payload: capture a beat whenever the input slot takes one
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_beat_ff.text <= req_text_byte;
         in_beat_ff.last <= req_is_last;
      end
      if (load_out) begin
         out_class_ff   <= step_class;
         out_pattern_ff <= canon_pattern(step_class, mode_ff);
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_literal_class     = out_class_ff;
   assign rsp_canonical_pattern = out_pattern_ff;

endmodule

// ===== design/flsc_checker.sv =====
// ----------------------------------------------------------------------------
// flsc_checker
// port-level checks for the float literal checker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "float_literal_syntax_checker_top_assert.svh"

module flsc_checker
   import flsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_literal_class,
   input logic [63:0] rsp_canonical_pattern
);

   // a stalled result beat holds
   `FLSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_literal_class) && $stable(rsp_canonical_pattern))

   // finite numbers carry a zero pattern
   `FLSC_ASSERT_NOW(a_finite_zero, rsp_valid && (rsp_literal_class == CLS_FINITE), rsp_canonical_pattern == PAT_FINITE)

   // every other class carries a nonzero pattern
   `FLSC_ASSERT_NOW(a_special_nonzero, rsp_valid && (rsp_literal_class != CLS_FINITE), rsp_canonical_pattern != PAT_FINITE)

   // input only backs up behind an untaken result
   `FLSC_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)

endmodule

bind float_literal_syntax_checker_top flsc_checker u_flsc_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// float literal syntax checker testbench
// streams literals one character beat at a time through the checker, mirrors
// the grammar walk in a local scanner and compares every class and canonical
// pattern against it or a typed directed verdict; both handshakes idle at random,
// the width mode toggles between phases, and one long response hold backs the block up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import flsc_pkg::*;

   // verdict of one closing beat
   typedef struct packed {
      class_type   cls;
      logic [63:0] pattern;
   } verdict_type;

   // directed literal: characters right-justified, first character highest
   typedef struct packed {
      logic [63:0] chars;
      logic [3:0]  len;
      logic        typed;
      class_type   cls;
      logic [63:0] pat;
   } lit_row_type;

   localparam int PHASE_COUNT = 6;
   localparam int PHASE_BEATS = 175;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER  = 500;

   // characters that steer the grammar, mixed into noise and broken literals
   localparam logic [7:0] HOT_CHARS [12] = '{
      CH_PLUS, CH_MINUS, CH_POINT, CH_LO_E, CH_UP_E, CH_LO_N,
      CH_LO_A, CH_LO_I, CH_LO_F, CH_ZERO, CH_NINE, 8'h00
   };

   // directed literals; the typed verdicts assume the reset width (double)
   localparam lit_row_type DIRECTED_ROWS [11] = '{
      '{"+",         4'd1, 1'b1, CLS_INVALID, PAT64_INVALID},  // lone sign
      '{"-inf",      4'd4, 1'b1, CLS_INF_NEG, PAT64_INF_NEG},
      '{"nan",       4'd3, 1'b1, CLS_NAN_POS, PAT64_NAN_POS},
      '{{"1", 8'h00}, 4'd2, 1'b1, CLS_INVALID, PAT64_INVALID}, // zero byte
      '{64'hff,      4'd1, 1'b1, CLS_INVALID, PAT64_INVALID},  // top byte value
      '{".",         4'd1, 1'b1, CLS_INVALID, PAT64_INVALID},  // point, no digits
      '{"5.",        4'd2, 1'b0, CLS_FINITE,  PAT_FINITE},
      '{".5",        4'd2, 1'b0, CLS_FINITE,  PAT_FINITE},
      '{"1e",        4'd2, 1'b1, CLS_INVALID, PAT64_INVALID},  // empty exponent
      '{"-1E+9",     4'd5, 1'b0, CLS_FINITE,  PAT_FINITE},
      '{"Nan",       4'd3, 1'b1, CLS_INVALID, PAT64_INVALID}   // cased word
   };

   logic        clock;
   logic        reset                 = 1'b1;
   logic        req_valid             = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte         = 8'h00;
   logic        req_is_last           = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready             = 1'b0;
   logic [2:0]  rsp_literal_class;
   logic [63:0] rsp_canonical_pattern;
   logic        csr_wr_en             = 1'b0;
   logic        csr_wr_data           = 1'b0;

   // scanner state, kept in step with the block
   phase_type lit_phase = PH_START;
   word_type  lit_word  = W_NONE;
   logic      lit_neg   = 1'b0;
   logic      lit_digit = 1'b0;
   logic      wide_mode = 1'b1;

   verdict_type verdicts_due [$];
   int          misses      = 0;
   int          beats_taken = 0;
   logic        calm        = 1'b0;   // no random idling on either side while set
   int          hold_left   = 0;
   logic        hold_done   = 1'b0;

   float_literal_syntax_checker_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_text_byte         (req_text_byte),
      .req_is_last           (req_is_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_literal_class     (rsp_literal_class),
      .rsp_canonical_pattern (rsp_canonical_pattern),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the run hangs anywhere
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // scanner: advances the literal grammar by one character
   // --------------------------------------------------------------------------

   function automatic logic [63:0] pattern_of(input class_type cls, input logic wide);
      logic [63:0] p32;
      logic [63:0] p64;
      p32 = PAT32_INVALID;
      p64 = PAT64_INVALID;
      case (cls)
         CLS_FINITE: begin
            p32 = PAT_FINITE;
            p64 = PAT_FINITE;
         end
         CLS_NAN_POS: begin
            p32 = PAT32_NAN_POS;
            p64 = PAT64_NAN_POS;
         end
         CLS_NAN_NEG: begin
            p32 = PAT32_NAN_NEG;
            p64 = PAT64_NAN_NEG;
         end
         CLS_INF_POS: begin
            p32 = PAT32_INF_POS;
            p64 = PAT64_INF_POS;
         end
         CLS_INF_NEG: begin
            p32 = PAT32_INF_NEG;
            p64 = PAT64_INF_NEG;
         end
         default: ;
      endcase
      return wide ? p64 : p32;
   endfunction

   function automatic void scan_char(input logic [7:0] ch, input logic last,
                                     output logic got, output verdict_type v);
      logic      dig;
      logic      sgn;
      logic      exp_letter;
      phase_type nxt;
      dig        = (ch >= CH_ZERO) && (ch <= CH_NINE);
      sgn        = (ch == CH_PLUS) || (ch == CH_MINUS);
      exp_letter = (ch == CH_LO_E) || (ch == CH_UP_E);
      nxt        = PH_DEAD;
      case (lit_phase)
         PH_START, PH_SIGN: begin
            // a sign is taken only as the very first character
            if (lit_phase == PH_START && sgn) begin
               lit_neg = (ch == CH_MINUS);
               nxt     = PH_SIGN;
            end else if (ch == CH_LO_N) begin
               lit_word = W_N;
               nxt      = PH_WORD;
            end else if (ch == CH_LO_I) begin
               lit_word = W_I;
               nxt      = PH_WORD;
            end else if (dig) begin
               lit_digit = 1'b1;
               nxt       = PH_INT;
            end else if (ch == CH_POINT) begin
               nxt = PH_DOT;
            end
         end
         PH_INT: begin
            if (dig) nxt = PH_INT;
            else if (ch == CH_POINT) nxt = PH_DOT;
            else if (exp_letter) nxt = PH_EXP;
         end
         PH_DOT: begin
            // exponent only once the mantissa holds a digit
            if (dig) begin
               lit_digit = 1'b1;
               nxt       = PH_DOT;
            end else if (exp_letter && lit_digit) begin
               nxt = PH_EXP;
            end
         end
         PH_EXP, PH_EXP_SIGN, PH_EXP_DIG: begin
            if (lit_phase == PH_EXP && sgn) nxt = PH_EXP_SIGN;
            else if (dig) nxt = PH_EXP_DIG;
         end
         PH_WORD: begin
            if (lit_word == W_N && ch == CH_LO_A) begin
               lit_word = W_NA;
               nxt      = PH_WORD;
            end else if (lit_word == W_NA && ch == CH_LO_N) begin
               lit_word = W_NAN;
               nxt      = PH_WORD;
            end else if (lit_word == W_I && ch == CH_LO_N) begin
               lit_word = W_IN;
               nxt      = PH_WORD;
            end else if (lit_word == W_IN && ch == CH_LO_F) begin
               lit_word = W_INF;
               nxt      = PH_WORD;
            end
         end
         default: nxt = PH_DEAD;
      endcase
      lit_phase = nxt;
      got       = last;
      v.cls     = CLS_INVALID;
      if (last) begin
         case (lit_phase)
            PH_INT, PH_EXP_DIG: v.cls = CLS_FINITE;
            PH_DOT:             v.cls = lit_digit ? CLS_FINITE : CLS_INVALID;
            PH_WORD: begin
               if (lit_word == W_NAN) v.cls = lit_neg ? CLS_NAN_NEG : CLS_NAN_POS;
               else if (lit_word == W_INF) v.cls = lit_neg ? CLS_INF_NEG : CLS_INF_POS;
            end
            default: v.cls = CLS_INVALID;
         endcase
         // closing beat returns the grammar to its start
         lit_phase = PH_START;
         lit_word  = W_NONE;
         lit_neg   = 1'b0;
         lit_digit = 1'b0;
      end
      v.pattern = pattern_of(v.cls, wide_mode);
   endfunction

   // --------------------------------------------------------------------------
   // literal builders for the random part
   // --------------------------------------------------------------------------

   function automatic logic [7:0] any_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic void push_sign(ref logic [7:0] lit [$]);
      case ($urandom_range(2))
         1: lit.push_back(CH_PLUS);
         2: lit.push_back(CH_MINUS);
         default: ;
      endcase
   endfunction

   // a literal the grammar accepts: finite number or signed word
   function automatic void well_formed(ref logic [7:0] lit [$]);
      int int_n;
      lit.delete();
      push_sign(lit);
      if ($urandom_range(3) == 0) begin
         if ($urandom_range(1)) begin
            lit.push_back(CH_LO_N);
            lit.push_back(CH_LO_A);
            lit.push_back(CH_LO_N);
         end else begin
            lit.push_back(CH_LO_I);
            lit.push_back(CH_LO_N);
            lit.push_back(CH_LO_F);
         end
      end else begin
         int_n = $urandom_range(4);
         repeat (int_n) lit.push_back(any_digit());
         // with no integer digits the fraction must carry one
         if (int_n == 0 || $urandom_range(1)) begin
            lit.push_back(CH_POINT);
            repeat ($urandom_range(3, int_n == 0 ? 1 : 0)) lit.push_back(any_digit());
         end
         if ($urandom_range(1)) begin
            lit.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
            push_sign(lit);
            repeat ($urandom_range(3, 1)) lit.push_back(any_digit());
         end
      end
   endfunction

   function automatic void build_literal(ref logic [7:0] lit [$]);
      int pick;
      int pos;
      pick = $urandom_range(99);
      if (pick < 70) begin
         well_formed(lit);
      end else if (pick < 85) begin
         // broken: one damaged spot in an otherwise good literal
         well_formed(lit);
         pos = $urandom_range(lit.size() - 1);
         case ($urandom_range(3))
            0: begin
               if (lit.size() > 1) void'(lit.pop_back());
               else lit[pos] = 8'($urandom_range(255));
            end
            1: lit[pos] = 8'($urandom_range(255));
            2: lit.insert(pos, HOT_CHARS[$urandom_range(11)]);
            default: lit[pos] = lit[pos] ^ 8'h20;   // flips letter case
         endcase
      end else begin
         // noise
         lit.delete();
         repeat ($urandom_range(5, 1)) begin
            if ($urandom_range(1)) lit.push_back(HOT_CHARS[$urandom_range(11)]);
            else lit.push_back(8'($urandom_range(255)));
         end
      end
   endfunction

   // --------------------------------------------------------------------------
   // character driver
   // --------------------------------------------------------------------------

   task automatic send_beat(input logic [7:0] ch, input logic last,
                            input logic typed, input verdict_type note);
      verdict_type guess;
      logic        got;
      // random gaps ahead of the beat
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= ch;
      req_is_last   <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
      beats_taken++;
      scan_char(ch, last, got, guess);
      if (got) verdicts_due.push_back(typed ? note : guess);
   endtask

   task automatic send_literal(input logic [7:0] lit [$], input logic typed,
                               input verdict_type note);
      foreach (lit[i]) send_beat(lit[i], i == lit.size() - 1, typed, note);
   endtask

   // wait until every pending result is taken, then let the pipeline settle
   task automatic drain();
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_width_mode(input logic wide);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= wide;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wide_mode = wide;
   endtask

   // --------------------------------------------------------------------------
   // response side: random stalls plus one long hold to back the block up
   // --------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 19);
      end
   end

   function automatic void log_miss(input string what, input logic [63:0] want,
                                    input logic [63:0] got);
      misses++;
      if (misses <= 10)
         $display("mismatch at %0t, %s: expected %h, got %h", $time, what, want, got);
   endfunction

   // result check against the oldest pending verdict
   always @(posedge clock) begin
      verdict_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            log_miss("result with nothing pending", 64'h0, rsp_canonical_pattern);
         end else begin
            due = verdicts_due.pop_front();
            if (rsp_literal_class !== due.cls)
               log_miss("literal_class", 64'(due.cls), 64'(rsp_literal_class));
            if (rsp_canonical_pattern !== due.pattern)
               log_miss("canonical_pattern", due.pattern, rsp_canonical_pattern);
         end
      end
   end

   // --------------------------------------------------------------------------
   // stimulus: directed table, then random phases over both width modes
   // --------------------------------------------------------------------------

   initial begin
      logic [7:0]  lit [$];
      verdict_type note;
      int          phase_beats;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows run in the reset width mode
      foreach (DIRECTED_ROWS[r]) begin
         lit.delete();
         for (int i = DIRECTED_ROWS[r].len - 1; i >= 0; i--)
            lit.push_back(DIRECTED_ROWS[r].chars[8*i +: 8]);
         note.cls     = DIRECTED_ROWS[r].cls;
         note.pattern = DIRECTED_ROWS[r].pat;
         send_literal(lit, DIRECTED_ROWS[r].typed, note);
      end

      // random phases alternate single and double width, single first
      note = '0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         req_valid <= 1'b0;
         drain();
         set_width_mode(ph[0]);
         calm <= (ph == 2);   // one phase runs without random idling
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS) begin
            build_literal(lit);
            phase_beats += lit.size();
            send_literal(lit, 1'b0, note);
         end
      end

      req_valid <= 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (misses == 0 && verdicts_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/flsc_pkg.sv
design/flsc_grammar.sv
design/float_literal_syntax_checker_top.sv
design/flsc_checker.sv
dv/tb.sv
